// File: hw/rtl/imufos_pkg.sv
// imufos_pkg: shared types, register map and constants for the imu frame
// offset and stillness unit
// no dependencies

package imufos_pkg;

  localparam int unsigned CAL_FRAMES_DEF = 5;
  localparam int unsigned FRAME_LAST     = 13;
  localparam int unsigned DIV_SHIFT      = 24;
  localparam int unsigned ACC_W          = 19;
  localparam int unsigned MAG_W          = 18;
  localparam int unsigned PADDR_W        = 4;

  localparam logic [15:0] ACCEL_OFF_X_RST = 16'd161;
  localparam logic [15:0] ACCEL_OFF_Y_RST = 16'd0;
  localparam logic [15:0] ACCEL_OFF_Z_RST = 16'd1700;
  localparam logic [15:0] STILL_THR_RST   = 16'd15;

  typedef enum logic [1:0] {
    ACT_DATA = 2'd0,
    ACT_CAL  = 2'd1,
    ACT_EN   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_ACCEL_OFF_X = 2'd0,
    REG_ACCEL_OFF_Y = 2'd1,
    REG_ACCEL_OFF_Z = 2'd2,
    REG_STILL_THR   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] accel_off_x;
    logic [15:0] accel_off_y;
    logic [15:0] accel_off_z;
    logic [15:0] still_thr;
  } cfg_t;

  typedef struct packed {
    logic                         start;
    logic [2:0][ACC_W-1:0]        acc;
  } cal_req_t;

endpackage

// File: hw/rtl/imufos_if.sv
// imufos_in_if / imufos_out_if: valid-ready channels for burst bytes and frame results
// no dependencies

interface imufos_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source(output valid, action, data_byte, input ready);
  modport sink(input valid, action, data_byte, output ready);
endinterface

interface imufos_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic [15:0]        motion_sum;
  logic [15:0]        still_count;
  logic               offsets_on;

  modport source(output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 motion_sum, still_count, offsets_on, input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
               motion_sum, still_count, offsets_on, output ready);
endinterface

// File: hw/rtl/imufos_cfg.sv
// imufos_cfg: apb register file for accel offsets and stillness threshold
// depends on imufos_pkg

module imufos_cfg
  import imufos_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_ACCEL_OFF_X: cfg_d.accel_off_x = pwdata[15:0];
        REG_ACCEL_OFF_Y: cfg_d.accel_off_y = pwdata[15:0];
        REG_ACCEL_OFF_Z: cfg_d.accel_off_z = pwdata[15:0];
        REG_STILL_THR:   cfg_d.still_thr   = pwdata[15:0];
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ACCEL_OFF_X: prdata = {16'd0, cfg_q.accel_off_x};
      REG_ACCEL_OFF_Y: prdata = {16'd0, cfg_q.accel_off_y};
      REG_ACCEL_OFF_Z: prdata = {16'd0, cfg_q.accel_off_z};
      REG_STILL_THR:   prdata = {16'd0, cfg_q.still_thr};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_off_x <= ACCEL_OFF_X_RST;
      cfg_q.accel_off_y <= ACCEL_OFF_Y_RST;
      cfg_q.accel_off_z <= ACCEL_OFF_Z_RST;
      cfg_q.still_thr   <= STILL_THR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/imufos_div.sv
// imufos_div: two-stage constant divider turning gyro sums into stored gyro offsets
// depends on imufos_pkg

module imufos_div
  import imufos_pkg::*;
#(
  parameter int unsigned CalFrames = CAL_FRAMES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cal_req_t         req_i,
  output logic [2:0][15:0] gyro_off_o
);

  localparam int unsigned RECIP_W = DIV_SHIFT + 1;
  localparam int unsigned PROD_W  = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(CalFrames) - 64'd1) / 64'(CalFrames));

  logic [2:0][PROD_W-1:0] prod_q, prod_d;
  logic [2:0]             neg_q, neg_d;
  logic                   stage_q;
  logic [2:0][15:0]       off_q, off_d;
  logic [2:0][MAG_W-1:0]  mag;
  logic [2:0][MAG_W-1:0]  quo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = req_i.acc[i][ACC_W-1];
      mag[i]   = neg_d[i] ? MAG_W'(-req_i.acc[i]) : MAG_W'(req_i.acc[i]);
      prod_d[i] = PROD_W'(mag[i]) * PROD_W'(RECIP);
    end
  end

  always_comb begin
    off_d = off_q;
    for (int i = 0; i < 3; i++) begin
      quo[i] = prod_q[i][DIV_SHIFT +: MAG_W];
      if (stage_q) begin
        off_d[i] = neg_q[i] ? 16'(-quo[i]) : quo[i][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= prod_d;
      neg_q  <= neg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      off_q   <= '0;
    end else begin
      stage_q <= req_i.start;
      off_q   <= off_d;
    end
  end

  assign gyro_off_o = off_q;

endmodule

// File: hw/rtl/imufos_core.sv
// imufos_core: input stage, burst assembly, offset correction, motion and stillness
// tracking, calibration accumulation and result register
// depends on imufos_pkg, imufos_if

module imufos_core
  import imufos_pkg::*;
#(
  parameter int unsigned CalFrames = CAL_FRAMES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  imufos_in_if.sink            in_i,
  imufos_out_if.source         out_o,
  input  cfg_t                 cfg_i,
  input  logic [2:0][15:0]     gyro_off_i,
  output cal_req_t             cal_req_o
);

  // input stage
  logic       s1_valid_q;
  logic [1:0] s1_action_q;
  logic [7:0] s1_byte_q;
  logic       out_free, s1_adv, in_xfer;

  // frame state
  logic [7:0]              frame_q [FRAME_LAST];
  logic [3:0]              pos_q, pos_d;
  logic [2:0][15:0]        prev_q, prev_d;
  logic                    off_en_q, off_en_d;
  logic [15:0]             still_q, still_d;
  logic                    cal_q, cal_d;
  logic [2:0]              seen_q, seen_d, seen_inc;
  logic [2:0][ACC_W-1:0]   acc_q, acc_d;
  logic                    done_q, done_d;
  logic                    byte_wr;

  // result register
  logic                    out_valid_q, out_valid_d, load;
  logic [15:0]             ax, ay, az;
  logic [2:0][15:0]        raw, g;
  logic [2:0][16:0]        diff, absd;
  logic [17:0]             sum_w;
  logic [15:0]             sum16;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer  = in_i.valid && in_i.ready;

  always_comb begin
    ay = {frame_q[0], frame_q[1]};
    ax = {frame_q[2], frame_q[3]};
    az = {frame_q[4], frame_q[5]};
    raw[1] = {frame_q[8], frame_q[9]};
    raw[0] = {frame_q[10], frame_q[11]};
    raw[2] = {frame_q[12], s1_byte_q};
    g = raw;
    if (off_en_q) begin
      ax = ax - cfg_i.accel_off_x;
      ay = ay - cfg_i.accel_off_y;
      az = az - cfg_i.accel_off_z;
      for (int i = 0; i < 3; i++) begin
        g[i] = raw[i] - gyro_off_i[i];
      end
    end
    sum_w = '0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {prev_q[i][15], prev_q[i]} - {g[i][15], g[i]};
      absd[i] = diff[i][16] ? 17'(-diff[i]) : diff[i];
      sum_w   = sum_w + 18'(absd[i]);
    end
    sum16 = sum_w[15:0];
  end

  assign seen_inc = seen_q + 3'd1;

  always_comb begin
    pos_d    = pos_q;
    prev_d   = prev_q;
    off_en_d = off_en_q;
    still_d  = still_q;
    cal_d    = cal_q;
    seen_d   = seen_q;
    acc_d    = acc_q;
    done_d   = 1'b0;
    byte_wr  = 1'b0;
    load     = 1'b0;
    if (s1_adv) begin
      case (s1_action_q)
        ACT_CAL: begin
          off_en_d = 1'b0;
          cal_d    = 1'b1;
          seen_d   = '0;
          acc_d    = '0;
        end
        ACT_EN: begin
          off_en_d = 1'b1;
        end
        ACT_DATA: begin
          if (pos_q >= 4'(FRAME_LAST)) begin
            pos_d  = '0;
            load   = 1'b1;
            prev_d = g;
            if (sum16 < cfg_i.still_thr) begin
              if (still_q != 16'hFFFF) begin
                still_d = still_q + 16'd1;
              end
            end else begin
              still_d = '0;
            end
            if (cal_q) begin
              for (int i = 0; i < 3; i++) begin
                acc_d[i] = acc_q[i] + {{(ACC_W-16){raw[i][15]}}, raw[i]};
              end
              seen_d = seen_inc;
              if (32'(seen_inc) >= CalFrames) begin
                done_d   = 1'b1;
                off_en_d = 1'b1;
                cal_d    = 1'b0;
                seen_d   = '0;
              end
            end
          end else begin
            byte_wr = 1'b1;
            pos_d   = pos_q + 4'd1;
          end
        end
        default: begin
          pos_d = pos_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_action_q <= in_i.action;
      s1_byte_q   <= in_i.data_byte;
    end
    if (byte_wr) begin
      frame_q[pos_q] <= s1_byte_q;
    end
    if (load) begin
      out_o.accel_x     <= ax;
      out_o.accel_y     <= ay;
      out_o.accel_z     <= az;
      out_o.gyro_x      <= g[0];
      out_o.gyro_y      <= g[1];
      out_o.gyro_z      <= g[2];
      out_o.motion_sum  <= sum16;
      out_o.still_count <= still_d;
      out_o.offsets_on  <= off_en_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      prev_q      <= '0;
      off_en_q    <= 1'b0;
      still_q     <= '0;
      cal_q       <= 1'b0;
      seen_q      <= '0;
      acc_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      s1_valid_q  <= in_xfer || (s1_valid_q && !s1_adv);
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      prev_q      <= prev_d;
      off_en_q    <= off_en_d;
      still_q     <= still_d;
      cal_q       <= cal_d;
      seen_q      <= seen_d;
      acc_q       <= acc_d;
      done_q      <= done_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign cal_req_o.start = done_q;
  assign cal_req_o.acc   = acc_q;

endmodule

// File: hw/rtl/imu_frame_offset_stillness_unit.sv
// imu_frame_offset_stillness_unit: top level of the imu burst assembler with offsets,
// stillness count and gyro calibration
// depends on imufos_pkg, imufos_if, imufos_cfg, imufos_div, imufos_core
//
//   channel  | dir | transfer content
//   in_i     | in  | action, data_byte
//   out_o    | out | accel xyz, gyro xyz, motion_sum, still_count, offsets_on
//   apb      | in  | accel offsets xyz, stillness threshold
//
// one item per cycle unless stalled: each item is registered in the input register, then its
// result (for the last burst byte) is written into the output register
// a full output register that is not taken stalls the input register and in_i
// gyro offsets settle after the last calibration frame, registered in done_q, prod_q and off_q
// reset is asynchronous and clears all control and tracking state

module imu_frame_offset_stillness_unit
  import imufos_pkg::*;
#(
  parameter int unsigned CalFrames = CAL_FRAMES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  imufos_in_if.sink          in_i,
  imufos_out_if.source       out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t             cfg;
  cal_req_t         cal_req;
  logic [2:0][15:0] gyro_off;

  imufos_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  imufos_div #(
    .CalFrames (CalFrames)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (cal_req),
    .gyro_off_o (gyro_off)
  );

  imufos_core #(
    .CalFrames (CalFrames)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .cfg_i      (cfg),
    .gyro_off_i (gyro_off),
    .cal_req_o  (cal_req)
  );

endmodule
